@@ sv/wrbf_pkg.sv @@
// Shared widths, types and helpers for the Wendland basis evaluator.
package wrbf_pkg;

  // Field widths
  localparam int IN_W  = 20;
  localparam int OUT_W = 24;

  // Internal fixed point: Q.24 magnitudes up to and including one
  localparam int QF = 24;
  localparam int QW = QF + 1;

  // Polynomial factor (signed, magnitude below 2^32), exact product and scaling
  localparam int PW   = QW + 9;
  localparam int MW   = QW + 1 + PW;
  localparam int MAGW = 57;
  localparam int KW   = 6;
  localparam int SW   = MAGW + KW;
  localparam int RW   = SW - QF;

  typedef logic [QW-1:0]        q_t;
  typedef logic signed [PW-1:0] poly_t;
  typedef logic signed [MW-1:0] prod_t;
  typedef logic [KW-1:0]        kmag_t;

  // Function order, named after the smoothness class
  typedef enum logic [1:0] {
    ORD_C0 = 2'd0,
    ORD_C2 = 2'd1,
    ORD_C4 = 2'd2,
    ORD_C6 = 2'd3
  } order_t;

  // Result field of one lane
  typedef enum logic [1:0] {
    FLD_VALUE = 2'd0,
    FLD_D1    = 2'd1,
    FLD_D2    = 2'd2
  } field_t;

  localparam q_t Q_ONE = {1'b1, {QF{1'b0}}};

  localparam logic [OUT_W-1:0] OUT_POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_NEG_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Radius and one minus radius after the front stage
  typedef struct packed {
    logic   in_support;
    order_t order;
    q_t     rad;
    q_t     u;
  } front_t;

  // Chosen power of u and polynomial factor for each result field
  typedef struct packed {
    logic   in_support;
    order_t order;
    q_t     pw_v;
    q_t     pw_d;
    q_t     pw_dd;
    poly_t  p_v;
    poly_t  p_d;
    poly_t  p_dd;
  } term_t;

  // Exact products before scaling and rounding
  typedef struct packed {
    logic   in_support;
    order_t order;
    prod_t  m_v;
    prod_t  m_d;
    prod_t  m_dd;
  } prod_set_t;

  // Q.24 product of two values in [0, 1], rounded half up
  function automatic q_t qmul_u(input q_t a, input q_t b);
    logic [2*QW-1:0] p;
    p = ({{QW{1'b0}}, a} * {{QW{1'b0}}, b}) + ((2*QW)'(1) << (QF - 1));
    return p[QF +: QW];
  endfunction

  // Zero-extend a Q.24 magnitude into the signed polynomial width
  function automatic poly_t to_poly(input q_t x);
    return $signed({{(PW-QW){1'b0}}, x});
  endfunction

  // Magnitude of the leading integer constant per order and field
  function automatic kmag_t scale_mag(input order_t ord, input field_t fld);
    kmag_t k;
    k = KW'(1);
    case (ord)
      ORD_C0:  k = (fld == FLD_VALUE) ? KW'(1) : KW'(2);
      ORD_C2:  k = (fld == FLD_VALUE) ? KW'(1) : KW'(20);
      ORD_C4:  k = (fld == FLD_VALUE) ? KW'(1) : KW'(56);
      ORD_C6:  k = (fld == FLD_VALUE) ? KW'(1) : KW'(22);
      default: k = KW'(1);
    endcase
    return k;
  endfunction

  // First derivative carries a negative leading constant
  function automatic logic scale_neg(input field_t fld);
    return fld == FLD_D1;
  endfunction

endpackage

@@ sv/wrbf_front.sv @@
// Front stage: absolute radius, support test and conversion to Q.24.
module wrbf_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [wrbf_pkg::IN_W-1:0]  in_radius,
  input  wrbf_pkg::order_t                  order,
  output logic                              out_valid,
  input  logic                              out_ready,
  output wrbf_pkg::front_t                  out_data
);

  localparam int RSH = wrbf_pkg::QF - FRAC_BITS;
  localparam logic [wrbf_pkg::QW:0] SUPPORT = (wrbf_pkg::QW + 1)'(1) << FRAC_BITS;

  logic [wrbf_pkg::IN_W-1:0] mag_w;
  logic                      inside_w;
  wrbf_pkg::front_t          data_nxt;
  wrbf_pkg::front_t          data_r;
  logic                      valid_r;
  logic                      rdy;

  // Take the magnitude; the most negative radius maps to 2^19 exactly
  always_comb begin
    mag_w    = in_radius[wrbf_pkg::IN_W-1] ? wrbf_pkg::IN_W'(~in_radius + 1'b1)
                                           : wrbf_pkg::IN_W'(in_radius);
    inside_w = {{(wrbf_pkg::QW + 1 - wrbf_pkg::IN_W){1'b0}}, mag_w} <= SUPPORT;
    data_nxt.in_support = inside_w;
    data_nxt.order      = order;
    data_nxt.rad        = inside_w ? (wrbf_pkg::q_t'(mag_w) << RSH) : '0;
    data_nxt.u          = wrbf_pkg::Q_ONE - data_nxt.rad;
  end

  assign rdy      = !valid_r || out_ready;
  assign in_ready = rdy;

  // Advance when the stage is empty or its item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rdy) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ sv/wrbf_powers.sv @@
// Power ladder of u and r, polynomial factors and per-order selection.
module wrbf_powers (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  wrbf_pkg::front_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output wrbf_pkg::term_t  out_data
);

  // Stage 2: squares
  logic             s2_valid_r;
  logic             s2_inside_r;
  wrbf_pkg::order_t s2_order_r;
  wrbf_pkg::q_t     s2_u_r, s2_u2_r, s2_rad_r, s2_rad2_r;

  // Stage 3: third and fourth powers
  logic             s3_valid_r;
  logic             s3_inside_r;
  wrbf_pkg::order_t s3_order_r;
  wrbf_pkg::q_t     s3_u_r, s3_u2_r, s3_u3_r, s3_u4_r;
  wrbf_pkg::q_t     s3_rad_r, s3_rad2_r, s3_rad3_r;

  // Stage 4: higher powers and polynomial factors
  logic             s4_valid_r;
  logic             s4_inside_r;
  wrbf_pkg::order_t s4_order_r;
  wrbf_pkg::q_t     s4_u_r, s4_u2_r, s4_u3_r, s4_u4_r, s4_u5_r, s4_u6_r, s4_u8_r;
  wrbf_pkg::poly_t  s4_pv_r, s4_pd_r, s4_pdd_r;

  // Stage 5: selected terms
  logic             s5_valid_r;
  wrbf_pkg::term_t  s5_term_r;
  wrbf_pkg::term_t  s5_term_nxt;

  logic rdy2, rdy3, rdy4, rdy5;

  wrbf_pkg::poly_t rs, r2s, r3s, one_s;
  wrbf_pkg::poly_t pv_nxt, pd_nxt, pdd_nxt;
  wrbf_pkg::q_t    u7_w;

  assign rdy5     = !s5_valid_r || out_ready;
  assign rdy4     = !s4_valid_r || rdy5;
  assign rdy3     = !s3_valid_r || rdy4;
  assign rdy2     = !s2_valid_r || rdy3;
  assign in_ready = rdy2;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      if (rdy2) s2_valid_r <= in_valid;
      if (rdy3) s3_valid_r <= s2_valid_r;
      if (rdy4) s4_valid_r <= s3_valid_r;
      if (rdy5) s5_valid_r <= s4_valid_r;
    end
  end

  // Square u and r
  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_inside_r <= in_data.in_support;
      s2_order_r  <= in_data.order;
      s2_u_r      <= in_data.u;
      s2_rad_r    <= in_data.rad;
      s2_u2_r     <= wrbf_pkg::qmul_u(in_data.u, in_data.u);
      s2_rad2_r   <= wrbf_pkg::qmul_u(in_data.rad, in_data.rad);
    end
  end

  // Form u^3, u^4 and r^3
  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_inside_r <= s2_inside_r;
      s3_order_r  <= s2_order_r;
      s3_u_r      <= s2_u_r;
      s3_u2_r     <= s2_u2_r;
      s3_u3_r     <= wrbf_pkg::qmul_u(s2_u2_r, s2_u_r);
      s3_u4_r     <= wrbf_pkg::qmul_u(s2_u2_r, s2_u2_r);
      s3_rad_r    <= s2_rad_r;
      s3_rad2_r   <= s2_rad2_r;
      s3_rad3_r   <= wrbf_pkg::qmul_u(s2_rad2_r, s2_rad_r);
    end
  end

  // Polynomial factors in r, exact integer coefficients
  always_comb begin
    rs    = wrbf_pkg::to_poly(s3_rad_r);
    r2s   = wrbf_pkg::to_poly(s3_rad2_r);
    r3s   = wrbf_pkg::to_poly(s3_rad3_r);
    one_s = wrbf_pkg::to_poly(wrbf_pkg::Q_ONE);
    case (s3_order_r)
      wrbf_pkg::ORD_C0: begin
        pv_nxt  = one_s;
        pd_nxt  = one_s;
        pdd_nxt = one_s;
      end
      wrbf_pkg::ORD_C2: begin
        pv_nxt  = one_s + (rs <<< 2);
        pd_nxt  = rs;
        pdd_nxt = (rs <<< 2) - one_s;
      end
      wrbf_pkg::ORD_C4: begin
        pv_nxt  = 3 * one_s + 18 * rs + 35 * r2s;
        pd_nxt  = rs + 5 * r2s;
        pdd_nxt = 35 * r2s - (rs <<< 2) - one_s;
      end
      default: begin
        pv_nxt  = one_s + (rs <<< 3) + 25 * r2s + (r3s <<< 5);
        pd_nxt  = rs + 7 * r2s + (r3s <<< 4);
        pdd_nxt = 15 * r2s + 160 * r3s - 6 * rs - one_s;
      end
    endcase
  end

  // Form u^5, u^6, u^8 and hold the factors
  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_inside_r <= s3_inside_r;
      s4_order_r  <= s3_order_r;
      s4_u_r      <= s3_u_r;
      s4_u2_r     <= s3_u2_r;
      s4_u3_r     <= s3_u3_r;
      s4_u4_r     <= s3_u4_r;
      s4_u5_r     <= wrbf_pkg::qmul_u(s3_u4_r, s3_u_r);
      s4_u6_r     <= wrbf_pkg::qmul_u(s3_u4_r, s3_u2_r);
      s4_u8_r     <= wrbf_pkg::qmul_u(s3_u4_r, s3_u4_r);
      s4_pv_r     <= pv_nxt;
      s4_pd_r     <= pd_nxt;
      s4_pdd_r    <= pdd_nxt;
    end
  end

  // Pick the power of u for each field; u^7 is formed here
  always_comb begin
    u7_w = wrbf_pkg::qmul_u(s4_u6_r, s4_u_r);
    s5_term_nxt.in_support = s4_inside_r;
    s5_term_nxt.order      = s4_order_r;
    s5_term_nxt.p_v        = s4_pv_r;
    s5_term_nxt.p_d        = s4_pd_r;
    s5_term_nxt.p_dd       = s4_pdd_r;
    case (s4_order_r)
      wrbf_pkg::ORD_C0: begin
        s5_term_nxt.pw_v  = s4_u2_r;
        s5_term_nxt.pw_d  = s4_u_r;
        s5_term_nxt.pw_dd = wrbf_pkg::Q_ONE;
      end
      wrbf_pkg::ORD_C2: begin
        s5_term_nxt.pw_v  = s4_u4_r;
        s5_term_nxt.pw_d  = s4_u3_r;
        s5_term_nxt.pw_dd = s4_u2_r;
      end
      wrbf_pkg::ORD_C4: begin
        s5_term_nxt.pw_v  = s4_u6_r;
        s5_term_nxt.pw_d  = s4_u5_r;
        s5_term_nxt.pw_dd = s4_u4_r;
      end
      default: begin
        s5_term_nxt.pw_v  = s4_u8_r;
        s5_term_nxt.pw_d  = u7_w;
        s5_term_nxt.pw_dd = s4_u6_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_term_r <= s5_term_nxt;
    end
  end

  assign out_valid = s5_valid_r;
  assign out_data  = s5_term_r;

endmodule

@@ sv/wrbf_mult.sv @@
// Exact product of each selected power of u with its polynomial factor.
module wrbf_mult (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wrbf_pkg::term_t     in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wrbf_pkg::prod_set_t out_data
);

  logic                valid_r;
  logic                rdy;
  wrbf_pkg::prod_set_t prod_nxt;
  wrbf_pkg::prod_set_t prod_r;

  assign rdy      = !valid_r || out_ready;
  assign in_ready = rdy;

  // One signed multiply per field
  always_comb begin
    prod_nxt.in_support = in_data.in_support;
    prod_nxt.order      = in_data.order;
    prod_nxt.m_v        = $signed({1'b0, in_data.pw_v}) * in_data.p_v;
    prod_nxt.m_d        = $signed({1'b0, in_data.pw_d}) * in_data.p_d;
    prod_nxt.m_dd       = $signed({1'b0, in_data.pw_dd}) * in_data.p_dd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rdy) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = prod_r;

endmodule

@@ sv/wrbf_round.sv @@
// Constant scaling, two rounding steps, saturation and the output register.
module wrbf_round #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  wrbf_pkg::prod_set_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [wrbf_pkg::OUT_W-1:0]   out_value,
  output logic signed [wrbf_pkg::OUT_W-1:0]   out_first_derivative,
  output logic signed [wrbf_pkg::OUT_W-1:0]   out_second_derivative
);

  localparam int SH = wrbf_pkg::QF - FRAC_BITS;

  logic s7_valid_r, s8_valid_r, s9_valid_r;
  logic s7_inside_r, s8_inside_r;
  logic rdy7, rdy8, rdy9;

  wrbf_pkg::prod_t            m_in  [3];
  logic [wrbf_pkg::OUT_W-1:0] res_q [3];

  assign m_in[0] = in_data.m_v;
  assign m_in[1] = in_data.m_d;
  assign m_in[2] = in_data.m_dd;

  assign rdy9     = !s9_valid_r || out_ready;
  assign rdy8     = !s8_valid_r || rdy9;
  assign rdy7     = !s7_valid_r || rdy8;
  assign in_ready = rdy7;

  // Valid bits and the support flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_valid_r <= 1'b0;
      s8_valid_r <= 1'b0;
      s9_valid_r <= 1'b0;
    end else begin
      if (rdy7) s7_valid_r <= in_valid;
      if (rdy8) s8_valid_r <= s7_valid_r;
      if (rdy9) s9_valid_r <= s8_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy7) s7_inside_r <= in_data.in_support;
    if (rdy8) s8_inside_r <= s7_inside_r;
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam wrbf_pkg::field_t LaneFld = wrbf_pkg::field_t'(i);

    logic [wrbf_pkg::MW-1:0]   mag_w;
    logic [wrbf_pkg::SW-1:0]   scaled_nxt;
    logic [wrbf_pkg::SW-1:0]   scaled_r;
    logic                      neg7_r;
    logic [wrbf_pkg::SW-1:0]   q_sum_w;
    logic [wrbf_pkg::RW-1:0]   q_r;
    logic                      neg8_r;
    logic [wrbf_pkg::RW:0]     fm;
    logic [wrbf_pkg::OUT_W-1:0] res_nxt;
    logic [wrbf_pkg::OUT_W-1:0] res_r;

    // Scale the magnitude by the leading constant; track the sign aside
    always_comb begin
      mag_w      = m_in[i][wrbf_pkg::MW-1] ? wrbf_pkg::MW'(-m_in[i])
                                           : wrbf_pkg::MW'(m_in[i]);
      scaled_nxt = wrbf_pkg::SW'(mag_w[wrbf_pkg::MAGW-1:0]) *
                   wrbf_pkg::SW'(wrbf_pkg::scale_mag(in_data.order, LaneFld));
    end

    always_ff @(posedge clk) begin
      if (rdy7) begin
        scaled_r <= scaled_nxt;
        neg7_r   <= m_in[i][wrbf_pkg::MW-1] ^ wrbf_pkg::scale_neg(LaneFld);
      end
    end

    // Round back to Q.24, half away from zero
    assign q_sum_w = scaled_r + (wrbf_pkg::SW'(1) << (wrbf_pkg::QF - 1));

    always_ff @(posedge clk) begin
      if (rdy8) begin
        q_r    <= q_sum_w[wrbf_pkg::QF +: wrbf_pkg::RW];
        neg8_r <= neg7_r;
      end
    end

    // Round to the field's fraction, half away from zero
    if (SH > 0) begin : g_rnd
      assign fm = ({1'b0, q_r} + ((wrbf_pkg::RW + 1)'(1) << (SH - 1))) >> SH;
    end else begin : g_exact
      assign fm = {1'b0, q_r};
    end

    // Saturate to the field range; zero outside the support
    always_comb begin
      if (!s8_inside_r) begin
        res_nxt = '0;
      end else if (neg8_r) begin
        if (fm >= (wrbf_pkg::RW + 1)'(wrbf_pkg::OUT_NEG_MIN)) begin
          res_nxt = wrbf_pkg::OUT_NEG_MIN;
        end else begin
          res_nxt = wrbf_pkg::OUT_W'(~fm[wrbf_pkg::OUT_W-1:0] + 1'b1);
        end
      end else begin
        if (fm > (wrbf_pkg::RW + 1)'(wrbf_pkg::OUT_POS_MAX)) begin
          res_nxt = wrbf_pkg::OUT_POS_MAX;
        end else begin
          res_nxt = fm[wrbf_pkg::OUT_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy9) begin
        res_r <= res_nxt;
      end
    end

    assign res_q[i] = res_r;
  end

  assign out_valid             = s9_valid_r;
  assign out_value             = $signed(res_q[0]);
  assign out_first_derivative  = $signed(res_q[1]);
  assign out_second_derivative = $signed(res_q[2]);

endmodule

@@ sv/wendland_rbf_eval.sv @@
// Top level of the Wendland compactly supported basis function evaluator.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   in      | input     | in_valid / in_ready  | in_radius (s20, FRAC_BITS fraction)
//   out     | output    | out_valid / out_ready| out_value, out_first_derivative,
//           |           |                      | out_second_derivative (s24, saturated)
//   cfg     | input     | cfg_wr_en            | cfg_rbf_order (2 bits)
//
// One item enters per cycle unless a full pipeline is held by out_ready low; each result
// passes through nine register stages. The depth is set by the power ladder of u (u^7
// needs four chained products) plus the product, scaling and two rounding stages.
// A stage holds its item while the next stage is full; empty stages still fill.
// Reset clears all valid bits and sets the order to zero.
module wendland_rbf_eval #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [wrbf_pkg::IN_W-1:0]   in_radius,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [wrbf_pkg::OUT_W-1:0]  out_value,
  output logic signed [wrbf_pkg::OUT_W-1:0]  out_first_derivative,
  output logic signed [wrbf_pkg::OUT_W-1:0]  out_second_derivative,
  input  logic                               cfg_wr_en,
  input  logic [1:0]                         cfg_rbf_order
);

  wrbf_pkg::order_t    order_r;

  logic                front_valid, front_ready;
  wrbf_pkg::front_t    front_data;
  logic                term_valid, term_ready;
  wrbf_pkg::term_t     term_data;
  logic                prod_valid, prod_ready;
  wrbf_pkg::prod_set_t prod_data;

  // Order register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= wrbf_pkg::ORD_C0;
    end else if (cfg_wr_en) begin
      order_r <= wrbf_pkg::order_t'(cfg_rbf_order);
    end
  end

  wrbf_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_radius (in_radius),
    .order     (order_r),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  wrbf_powers u_powers (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (term_valid),
    .out_ready (term_ready),
    .out_data  (term_data)
  );

  wrbf_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (term_valid),
    .in_ready  (term_ready),
    .in_data   (term_data),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_data  (prod_data)
  );

  wrbf_round #(
    .FRAC_BITS (FRAC_BITS)
  ) u_round (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (prod_valid),
    .in_ready              (prod_ready),
    .in_data               (prod_data),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_value             (out_value),
    .out_first_derivative  (out_first_derivative),
    .out_second_derivative (out_second_derivative)
  );

endmodule

@@ sv/wrbf_checker.sv @@
// Port-level checks for the Wendland evaluator, bound to the top level.
module wrbf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [23:0] out_value,
  input logic signed [23:0] out_first_derivative,
  input logic signed [23:0] out_second_derivative
);

  // No result may be shown in the cycle after a reset edge
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) &&
      $stable(out_first_derivative) && $stable(out_second_derivative))
    else $error("stalled result changed or dropped");

  // The basis value is never negative
  a_value_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_value[23])
    else $error("negative basis value");

  // The function falls with the radius, so the slope is never positive
  a_slope_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_first_derivative[23] || out_first_derivative == 24'sd0))
    else $error("positive first derivative");

endmodule

bind wendland_rbf_eval wrbf_checker u_wrbf_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_value             (out_value),
  .out_first_derivative  (out_first_derivative),
  .out_second_derivative (out_second_derivative)
);
